>>> src/assert_macros.svh
// Assertion macros used by the checker file lsrc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every clock edge, also during reset.
`define ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> src/lsrc_pkg.sv
// Package for the Liang-Barsky segment clipper: widths, register map, payload types.
// No dependencies.
`default_nettype none
package lsrc_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_WIDTH    = 4;
  localparam int DATA_WIDTH    = 32;

  localparam logic [COORD_WIDTH-1:0] LEFT_RST   = COORD_WIDTH'(0);
  localparam logic [COORD_WIDTH-1:0] TOP_RST    = COORD_WIDTH'(0);
  localparam logic [COORD_WIDTH-1:0] RIGHT_RST  = COORD_WIDTH'(122880);
  localparam logic [COORD_WIDTH-1:0] BOTTOM_RST = COORD_WIDTH'(69120);

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic                          visible;
    logic signed [COORD_WIDTH-1:0] clipped_start_x;
    logic signed [COORD_WIDTH-1:0] clipped_start_y;
    logic signed [COORD_WIDTH-1:0] clipped_end_x;
    logic signed [COORD_WIDTH-1:0] clipped_end_y;
  } clip_t;

  // per-edge flags carried alongside the divider
  typedef struct packed {
    logic pzero;
    logic pneg;
    logic qneg;
    logic tneg;
  } edge_flags_t;

endpackage
`default_nettype wire

>>> src/lsrc_div.sv
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), saturated at 2^(FRAC_BITS+1).
// One quotient bit per stage, FRAC_BITS+1 stages. Uses lsrc_pkg.
`default_nettype none
module lsrc_div
  import lsrc_pkg::*;
#(
  parameter int MAG_W     = COORD_WIDTH + 1,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic [MAG_W-1:0]     num,
  input  wire logic [MAG_W-1:0]     den,
  output logic      [FRAC_BITS+1:0] quo
);

  localparam int STAGES = FRAC_BITS + 1;
  localparam int REM_W  = MAG_W + 1;

  logic [REM_W-1:0]   rem   [STAGES];
  logic [MAG_W-1:0]   den_s [STAGES];
  logic [FRAC_BITS:0] q_s   [STAGES];
  logic               sat_s [STAGES];

  // integer bit and saturation check
  always_ff @(posedge clk) begin
    den_s[0] <= den;
    sat_s[0] <= {1'b0, num} >= {den, 1'b0};
    if (num >= den) begin
      rem[0] <= {1'b0, num - den};
      q_s[0] <= (FRAC_BITS+1)'(1);
    end else begin
      rem[0] <= {1'b0, num};
      q_s[0] <= '0;
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_step
    logic [REM_W-1:0] rem2;
    logic             bit_q;
    assign rem2  = {rem[k-1][REM_W-2:0], 1'b0};
    assign bit_q = rem2 >= {1'b0, den_s[k-1]};
    always_ff @(posedge clk) begin
      den_s[k] <= den_s[k-1];
      sat_s[k] <= sat_s[k-1];
      rem[k]   <= bit_q ? rem2 - {1'b0, den_s[k-1]} : rem2;
      q_s[k]   <= {q_s[k-1][FRAC_BITS-1:0], bit_q};
    end
  end

  assign quo = sat_s[STAGES-1] ? {1'b1, {(FRAC_BITS+1){1'b0}}} : {1'b0, q_s[STAGES-1]};

endmodule
`default_nettype wire

>>> src/lsrc_delay.sv
// Fixed-depth delay line for side data that travels with the divider.
// Uses lsrc_pkg for defaults only.
`default_nettype none
module lsrc_delay
  import lsrc_pkg::*;
#(
  parameter int WIDTH = COORD_WIDTH,
  parameter int DEPTH = FRAC_BITS_DEF + 1
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

>>> src/lsrc_lerp.sv
// Interpolation base + round(t * d): multiply stage, then round and add stage.
// Result is forced to zero when keep is low. Uses lsrc_pkg.
`default_nettype none
module lsrc_lerp
  import lsrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic signed [COORD_WIDTH-1:0] base,
  input  wire logic signed [COORD_WIDTH:0]   d,
  input  wire logic        [FRAC_BITS:0]     t,
  input  wire logic                          keep,
  output logic      signed [COORD_WIDTH-1:0] coord
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = FRAC_BITS + W + 2;

  logic [W:0]            mag;
  logic [PW-1:0]         prod;
  logic                  dneg;
  logic                  keep1;
  logic signed [W-1:0]   base1;
  logic [PW-1:0]         rnd;
  logic [W:0]            r;
  logic [W:0]            sum;

  assign mag = d[W] ? (W+1)'(-d) : d;

  always_ff @(posedge clk) begin
    prod  <= PW'(t) * PW'(mag);
    dneg  <= d[W];
    keep1 <= keep;
    base1 <= base;
  end

  // round half away from zero on the magnitude
  assign rnd = prod + (PW'(1) << (FRAC_BITS - 1));
  assign r   = rnd[FRAC_BITS +: W+1];
  assign sum = dneg ? {base1[W-1], base1} - r : {base1[W-1], base1} + r;

  always_ff @(posedge clk) begin
    coord <= keep1 ? sum[W-1:0] : '0;
  end

endmodule
`default_nettype wire

>>> src/line_segment_rect_clip.sv
// Channel   | Signals                          | Direction
// segment   | start, busy, segment             | in
// result    | done, result                     | out
// window    | psel penable pwrite paddr pwdata | cfg (APB, pready tied high)
//
// One segment accepted per clock; busy stays low. Pipeline: two setup
// stages, the FRAC_BITS+1 stage divider (one quotient bit per stage, four in
// parallel), one decision stage and two interpolation stages. Reset is
// synchronous, loads the window registers with their reset values and
// clears the valid line. done cannot be held off.
// Top level of the Liang-Barsky clipper; uses lsrc_pkg, lsrc_div, lsrc_delay, lsrc_lerp.
`default_nettype none
module line_segment_rect_clip
  import lsrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire seg_t                  segment,
  output logic                       done,
  output clip_t                      result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready
);

  localparam int W       = COORD_WIDTH;
  localparam int DIV_LAT = FRAC_BITS + 1;
  localparam int TW      = FRAC_BITS + 2;
  localparam int SIDE_W  = 4 * $bits(edge_flags_t) + 2 * W + 2 * (W + 1);

  // ---------------- configuration ----------------
  logic [W-1:0] win_left, win_top, win_right, win_bottom;
  reg_idx_t     widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= LEFT_RST;
      win_top    <= TOP_RST;
      win_right  <= RIGHT_RST;
      win_bottom <= BOTTOM_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_LEFT:   win_left   <= pwdata[W-1:0];
        REG_TOP:    win_top    <= pwdata[W-1:0];
        REG_RIGHT:  win_right  <= pwdata[W-1:0];
        REG_BOTTOM: win_bottom <= pwdata[W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_LEFT:   prdata = win_left;
      REG_TOP:    prdata = win_top;
      REG_RIGHT:  prdata = win_right;
      REG_BOTTOM: prdata = win_bottom;
      default:    prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------- stage A: differences ----------------
  logic                a_valid;
  logic signed [W-1:0] a_ax, a_ay;
  logic signed [W:0]   a_dx, a_dy;
  logic signed [W:0]   a_q [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_ax   <= segment.start_x;
    a_ay   <= segment.start_y;
    a_dx   <= {segment.end_x[W-1], segment.end_x} - {segment.start_x[W-1], segment.start_x};
    a_dy   <= {segment.end_y[W-1], segment.end_y} - {segment.start_y[W-1], segment.start_y};
    a_q[0] <= {segment.start_x[W-1], segment.start_x} - {win_left[W-1], win_left};
    a_q[1] <= {win_right[W-1], win_right} - {segment.start_x[W-1], segment.start_x};
    a_q[2] <= {segment.start_y[W-1], segment.start_y} - {win_top[W-1], win_top};
    a_q[3] <= {win_bottom[W-1], win_bottom} - {segment.start_y[W-1], segment.start_y};
  end

  // ---------------- stage B: magnitudes and sign flags ----------------
  logic signed [W:0] a_p [4];
  assign a_p[0] = -a_dx;
  assign a_p[1] = a_dx;
  assign a_p[2] = -a_dy;
  assign a_p[3] = a_dy;

  logic                b_valid;
  logic [W:0]          b_pa [4];
  logic [W:0]          b_qa [4];
  edge_flags_t         b_fl [4];
  logic signed [W-1:0] b_ax, b_ay;
  logic signed [W:0]   b_dx, b_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_ax <= a_ax;
    b_ay <= a_ay;
    b_dx <= a_dx;
    b_dy <= a_dy;
    for (int i = 0; i < 4; i++) begin
      b_pa[i]       <= a_p[i][W] ? (W+1)'(-a_p[i]) : a_p[i];
      b_qa[i]       <= a_q[i][W] ? (W+1)'(-a_q[i]) : a_q[i];
      b_fl[i].pzero <= a_p[i] == '0;
      b_fl[i].pneg  <= a_p[i][W];
      b_fl[i].qneg  <= a_q[i][W];
      b_fl[i].tneg  <= (a_q[i] != '0) && (a_q[i][W] != a_p[i][W]);
    end
  end

  // ---------------- dividers ----------------
  logic [TW-1:0] c_t [4];

  for (genvar e = 0; e < 4; e++) begin : g_div
    lsrc_div #(.MAG_W(W + 1), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .num (b_qa[e]),
      .den (b_pa[e]),
      .quo (c_t[e])
    );
  end

  logic [SIDE_W-1:0]   side_in, side_out;
  edge_flags_t         c_fl [4];
  logic signed [W-1:0] c_ax, c_ay;
  logic signed [W:0]   c_dx, c_dy;
  logic [DIV_LAT-1:0]  vline;

  assign side_in = {b_fl[0], b_fl[1], b_fl[2], b_fl[3], b_ax, b_ay, b_dx, b_dy};
  assign {c_fl[0], c_fl[1], c_fl[2], c_fl[3], c_ax, c_ay, c_dx, c_dy} = side_out;

  lsrc_delay #(.WIDTH(SIDE_W), .DEPTH(DIV_LAT)) u_side (
    .clk  (clk),
    .din  (side_in),
    .dout (side_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else begin
      vline <= {vline[DIV_LAT-2:0], b_valid};
    end
  end

  // ---------------- decision: narrow entry/exit params ----------------
  logic          vis_c;
  logic [TW-1:0] t0_c, t1_c;

  always_comb begin
    vis_c = 1'b1;
    t0_c  = '0;
    t1_c  = TW'(1) << FRAC_BITS;
    for (int i = 0; i < 4; i++) begin
      if (vis_c) begin
        if (c_fl[i].pzero) begin
          if (c_fl[i].qneg) vis_c = 1'b0;
        end else if (c_fl[i].pneg) begin
          if (!c_fl[i].tneg && c_t[i] > t1_c) vis_c = 1'b0;
          else if (!c_fl[i].tneg && c_t[i] > t0_c) t0_c = c_t[i];
        end else begin
          if (c_fl[i].tneg || c_t[i] < t0_c) vis_c = 1'b0;
          else if (c_t[i] < t1_c) t1_c = c_t[i];
        end
      end
    end
  end

  logic                 d_valid, d_vis;
  logic [FRAC_BITS:0]   d_t0, d_t1;
  logic signed [W-1:0]  d_ax, d_ay;
  logic signed [W:0]    d_dx, d_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= vline[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    d_vis <= vis_c;
    d_t0  <= t0_c[FRAC_BITS:0];
    d_t1  <= t1_c[FRAC_BITS:0];
    d_ax  <= c_ax;
    d_ay  <= c_ay;
    d_dx  <= c_dx;
    d_dy  <= c_dy;
  end

  // ---------------- interpolation ----------------
  logic [1:0] e_valid;
  logic       e_vis, f_vis;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= '0;
    end else begin
      e_valid <= {e_valid[0], d_valid};
    end
  end

  always_ff @(posedge clk) begin
    e_vis <= d_vis;
    f_vis <= e_vis;
  end

  lsrc_lerp #(.FRAC_BITS(FRAC_BITS)) u_sx (
    .clk(clk), .base(d_ax), .d(d_dx), .t(d_t0), .keep(d_vis), .coord(result.clipped_start_x)
  );
  lsrc_lerp #(.FRAC_BITS(FRAC_BITS)) u_sy (
    .clk(clk), .base(d_ay), .d(d_dy), .t(d_t0), .keep(d_vis), .coord(result.clipped_start_y)
  );
  lsrc_lerp #(.FRAC_BITS(FRAC_BITS)) u_ex (
    .clk(clk), .base(d_ax), .d(d_dx), .t(d_t1), .keep(d_vis), .coord(result.clipped_end_x)
  );
  lsrc_lerp #(.FRAC_BITS(FRAC_BITS)) u_ey (
    .clk(clk), .base(d_ay), .d(d_dy), .t(d_t1), .keep(d_vis), .coord(result.clipped_end_y)
  );

  assign result.visible = f_vis;
  assign done           = e_valid[1];

endmodule
`default_nettype wire

>>> src/lsrc_checker.sv
// Port-level checker for line_segment_rect_clip, attached by bind.
// Uses lsrc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lsrc_checker
  import lsrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  start,
  input wire logic  busy,
  input wire logic  done,
  input wire clip_t result
);

  localparam int LAT = FRAC_BITS + 6;

  logic coords_zero;

  assign coords_zero = result.clipped_start_x == '0 && result.clipped_start_y == '0 &&
                       result.clipped_end_x == '0 && result.clipped_end_y == '0;

  `ASSERT_CLK(a_never_busy, clk, rst, !busy)
  `ASSERT_ALL(a_reset_flush, clk, rst |=> !done)
  `ASSERT_CLK(a_done_has_item, clk, rst, done |-> $past(start, LAT))
  `ASSERT_CLK(a_reject_zero, clk, rst, (done && !result.visible) |-> coords_zero)

endmodule

bind line_segment_rect_clip lsrc_checker #(.FRAC_BITS(FRAC_BITS)) u_lsrc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

>>> bench/tb_line_segment_rect_clip.sv
`timescale 1ns / 1ps
// Self-checking bench for line_segment_rect_clip: directed table, then random segments.
// Depends on lsrc_pkg and the clipper RTL.
module tb_line_segment_rect_clip;
  import lsrc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint T_ONE = longint'(1) << FB;
  localparam int LATENCY = FB + 6;
  localparam int WATCHDOG = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  seg_t segment = '0;
  logic done;
  clip_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;

  line_segment_rect_clip i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .segment(segment),
    .done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [COORD_WIDTH-1:0] win_l, win_t, win_r, win_b;
  clip_t clip_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;

  // unsigned t magnitude, saturated at 2.0
  function automatic longint unsigned edge_ratio(longint unsigned qa, longint unsigned pa);
    longint unsigned quo, rem;
    if (qa / 2 >= pa) return 2 * T_ONE;
    quo = qa / pa;
    rem = qa % pa;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= pa) begin
        rem = rem - pa;
        quo = quo | 1;
      end
    end
    return quo;
  endfunction

  function automatic longint interp(longint base, longint d, longint unsigned t);
    longint unsigned m, r;
    m = d < 0 ? longint'(-d) : d;
    r = (t * m + (longint'(1) << (FB - 1))) >> FB;
    return d < 0 ? base - longint'(r) : base + longint'(r);
  endfunction

  function automatic clip_t predict_clip(seg_t s);
    longint ax, ay, dx, dy, r;
    longint p[4], q[4];
    longint unsigned t0, t1, m;
    logic vis, neg;
    clip_t c;
    ax = s.start_x; ay = s.start_y;
    dx = longint'(s.end_x) - ax;
    dy = longint'(s.end_y) - ay;
    p[0] = -dx; q[0] = ax - longint'(win_l);
    p[1] = dx;  q[1] = longint'(win_r) - ax;
    p[2] = -dy; q[2] = ay - longint'(win_t);
    p[3] = dy;  q[3] = longint'(win_b) - ay;
    t0 = 0; t1 = T_ONE; vis = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (!vis) continue;
      if (p[i] == 0) begin
        if (q[i] < 0) vis = 1'b0;
        continue;
      end
      neg = (q[i] != 0) && ((q[i] < 0) != (p[i] < 0));
      m = edge_ratio(q[i] < 0 ? -q[i] : q[i], p[i] < 0 ? -p[i] : p[i]);
      if (p[i] < 0) begin
        if (!neg && m > t1) vis = 1'b0;
        else if (!neg && m > t0) t0 = m;
      end else begin
        if (neg || m < t0) vis = 1'b0;
        else if (m < t1) t1 = m;
      end
    end
    c = '0;
    if (vis) begin
      c.visible = 1'b1;
      r = interp(ax, dx, t0); c.clipped_start_x = r[COORD_WIDTH-1:0];
      r = interp(ay, dy, t0); c.clipped_start_y = r[COORD_WIDTH-1:0];
      r = interp(ax, dx, t1); c.clipped_end_x = r[COORD_WIDTH-1:0];
      r = interp(ay, dy, t1); c.clipped_end_y = r[COORD_WIDTH-1:0];
    end
    return c;
  endfunction

  // result checker; done cannot be stalled so every strobe is consumed
  always @(posedge clk) begin
    if (!rst && done) begin
      clip_t want;
      if (clip_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = clip_queue.pop_front();
        if (result.visible !== want.visible ||
            result.clipped_start_x !== want.clipped_start_x ||
            result.clipped_start_y !== want.clipped_start_y ||
            result.clipped_end_x !== want.clipped_end_x ||
            result.clipped_end_y !== want.clipped_end_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL line_segment_rect_clip");
      $finish;
    end
  end

  task automatic write_window(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_WIDTH'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LEFT:   win_l = value;
      REG_TOP:    win_t = value;
      REG_RIGHT:  win_r = value;
      REG_BOTTOM: win_b = value;
    endcase
  endtask

  task automatic set_window(logic [31:0] l, logic [31:0] t, logic [31:0] r, logic [31:0] b);
    write_window(REG_LEFT, l);
    write_window(REG_TOP, t);
    write_window(REG_RIGHT, r);
    write_window(REG_BOTTOM, b);
  endtask

  task automatic drain();
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  int burst_left = 0;

  // drives one segment with random burst gaps; start stays high across items
  task automatic send_segment(seg_t s, logic use_table, clip_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    start <= 1'b1;
    segment <= s;
    do @(posedge clk); while (busy);
    clip_queue.push_back(use_table ? want : predict_clip(s));
    burst_left--;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 180000)) - 30000);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  typedef struct {
    seg_t s;
    logic fixed;
    clip_t want;
  } seg_row_t;

  seg_row_t table_rows[$];

  initial begin
    seg_t s;
    clip_t z;
    win_l = LEFT_RST; win_t = TOP_RST; win_r = RIGHT_RST; win_b = BOTTOM_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    z = '0;
    // fully inside at reset window: unchanged
    table_rows.push_back('{'{640, 640, 6400, 6400}, 1, '{1'b1, 640, 640, 6400, 6400}});
    // degenerate point inside, on the corner, outside
    table_rows.push_back('{'{100, 100, 100, 100}, 1, '{1'b1, 100, 100, 100, 100}});
    table_rows.push_back('{'{122880, 69120, 122880, 69120}, 1,
                          '{1'b1, 122880, 69120, 122880, 69120}});
    table_rows.push_back('{'{-1, 5, -1, 5}, 1, z});
    // parallel and outside
    table_rows.push_back('{'{-64, 0, -64, 6400}, 1, z});
    table_rows.push_back('{'{0, 70000, 6400, 70000}, 1, z});
    // crossing windows and extremes
    table_rows.push_back('{'{-6400, 640, 200000, 640}, 0, z});
    table_rows.push_back('{'{640, -6400, 640, 100000}, 0, z});
    table_rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 0, z});
    table_rows.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000}, 0, z});
    table_rows.push_back('{'{32'h8000_0000, 0, 32'h8000_0000, 0}, 1, z});
    table_rows.push_back('{'{-100, -100, -10, -10}, 1, z});
    table_rows.push_back('{'{200000, 80000, -1000, -1000}, 0, z});
    table_rows.push_back('{'{1, 2, 3, 100000}, 0, z});
    foreach (table_rows[i]) send_segment(table_rows[i].s, table_rows[i].fixed, table_rows[i].want);
    start <= 1'b0;
    drain();

    // random phases across window settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        1: set_window(-640, -640, 640, 640);
        2: set_window(1000, 1000, -1000, -1000);
        3: set_window(0, 0, 0, 0);
        4: set_window($urandom(), $urandom(), $urandom(), $urandom());
        default: set_window(-12800, 3200, 150000, 60000);
      endcase
      for (int n = 0; n < 160; n++) begin
        int mode;
        mode = $urandom_range(0, 2);
        s.start_x = rand_coord(mode); s.start_y = rand_coord(mode);
        if ($urandom_range(0, 9) == 0) begin
          s.end_x = s.start_x; s.end_y = s.start_y;
        end else if ($urandom_range(0, 5) == 0) begin
          s.end_x = s.start_x; s.end_y = rand_coord(mode);
        end else begin
          s.end_x = rand_coord(mode); s.end_y = rand_coord(mode);
        end
        send_segment(s, 1'b0, z);
        if (n == 80) begin
          start <= 1'b0;
          burst_left = 0;
          while (clip_queue.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      burst_left = 0;
      drain();
    end

    if (mismatches == 0 && clip_queue.size() == 0) begin
      $display("PASS line_segment_rect_clip");
    end else begin
      $display("FAIL line_segment_rect_clip");
    end
    $finish;
  end
endmodule
